/* src/emacc_pkg.sv */
// emacc_pkg: types, field widths and saturation ceilings for the error
// metrics accumulator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package emacc_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned MAX_ITEMS_DEF  = 65536;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SQR_W   = 32;
  localparam int unsigned HD_W    = 5;
  localparam int unsigned HDC_W   = 6;   // count up to 32 bits
  localparam int unsigned EXT_W   = 32;  // widest data width supported
  localparam int unsigned SQS_W   = 48;
  localparam int unsigned ABS_W   = 32;
  localparam int unsigned CNT_O_W = 17;
  localparam int unsigned HDS_W   = 21;

  localparam logic [SQS_W-1:0] SQ_CAP  = 48'd281466386841600;
  localparam logic [ABS_W-1:0] ABS_CAP = 32'd4294901760;
  localparam logic [HDS_W-1:0] HD_CAP  = 21'd1048576;

  typedef struct packed {
    logic signed [VAL_W-1:0] expected_value;
    logic signed [VAL_W-1:0] actual_value;
    logic                    last_item;
  } in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] difference;
    logic [HD_W-1:0]          bit_distance;
    logic [SQS_W-1:0]         squared_sum;
    logic [ABS_W-1:0]         absolute_sum;
    logic [MAG_W-1:0]         worst_difference;
    logic [CNT_O_W-1:0]       mismatch_total;
    logic [HDS_W-1:0]         bit_distance_sum;
    logic [CNT_O_W-1:0]       items_seen;
    logic                     set_done;
  } out_t;

  // per-pair metrics handed to the totals stage
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [SQR_W-1:0] sqr;
    logic [HDC_W-1:0] hd;
    logic             mismatch;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic [SQS_W-1:0]   squared_sum;
    logic [ABS_W-1:0]   absolute_sum;
    logic [MAG_W-1:0]   worst_difference;
    logic [CNT_O_W-1:0] mismatch_total;
    logic [HDS_W-1:0]   bit_distance_sum;
    logic [CNT_O_W-1:0] items_seen;
  } totals_t;

endpackage

`default_nettype wire

/* src/error_metrics_accumulator.sv */
// error_metrics_accumulator: top level, three-stage pipeline computing
// per-pair error metrics and running totals. Depends on emacc_pkg, emacc_totals.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one pair (expected, actual,
//   last_item) per beat. Output channel out_valid_o / out_stall_i carries one
//   result per input beat, in order: difference, Hamming distance and the set
//   totals including that pair.
//   From input to result a beat passes the input register, the pair metrics
//   register (subtract and 17x17 square) and the output register, where the
//   totals are accumulated. One beat per cycle is sustained while out_stall_i
//   is low; the add-and-saturate loop of the last stage has no register inside.
//   A beat with last_item set returns the final totals of its set with
//   set_done high; all totals restart from zero for the next beat.
//   Reset empties the pipeline and clears all totals.
//   When out_stall_i is held, the result holds and the pipeline keeps taking
//   beats until its two inner stages are full, then in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module error_metrics_accumulator #(
  parameter int unsigned DATA_WIDTH = emacc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned MAX_ITEMS  = emacc_pkg::MAX_ITEMS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire emacc_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output emacc_pkg::out_t      out_data_o
);
  import emacc_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  in_t   in_q;
  pair_t pair_q, pair_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  out_t  out_q, out_d;
  totals_t totals;

  logic signed [2*DIFF_W-1:0] sqr_full;
  logic [DIFF_W-1:0]          mag_full;
  logic [EXT_W-1:0]           xor_ext;
  logic [HDC_W-1:0]           hd;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) in_q <= in_data_i;
  end

  // pair metrics
  always_comb begin
    diff_d = $signed({in_q.expected_value[VAL_W-1], in_q.expected_value})
           - $signed({in_q.actual_value[VAL_W-1], in_q.actual_value});
    sqr_full = diff_d * diff_d;
    mag_full = diff_d[DIFF_W-1] ? DIFF_W'(-diff_d) : DIFF_W'(diff_d);
    xor_ext  = {{(EXT_W - VAL_W){in_q.expected_value[VAL_W-1]}}, in_q.expected_value}
             ^ {{(EXT_W - VAL_W){in_q.actual_value[VAL_W-1]}}, in_q.actual_value};
    hd = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      hd = hd + HDC_W'(xor_ext[i]);
    end
    pair_d.mag      = mag_full[MAG_W-1:0];
    pair_d.sqr      = sqr_full[SQR_W-1:0];
    pair_d.hd       = hd;
    pair_d.mismatch = (in_q.expected_value != in_q.actual_value);
    pair_d.last     = in_q.last_item;
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pair_q <= pair_d;
      diff_q <= diff_d;
    end
  end

  emacc_totals #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_totals (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (en3 && v2_q),
    .pair_i   (pair_q),
    .totals_o (totals)
  );

  always_comb begin
    out_d.difference       = diff_q;
    out_d.bit_distance     = pair_q.hd[HD_W-1:0];
    out_d.squared_sum      = totals.squared_sum;
    out_d.absolute_sum     = totals.absolute_sum;
    out_d.worst_difference = totals.worst_difference;
    out_d.mismatch_total   = totals.mismatch_total;
    out_d.bit_distance_sum = totals.bit_distance_sum;
    out_d.items_seen       = totals.items_seen;
    out_d.set_done         = pair_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) out_q <= out_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* src/emacc_totals.sv */
// emacc_totals: saturating running totals over one set, cleared after the
// last beat of a set. Depends on emacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emacc_totals #(
  parameter int unsigned MAX_ITEMS = emacc_pkg::MAX_ITEMS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              upd_i,
  input  wire emacc_pkg::pair_t  pair_i,
  output emacc_pkg::totals_t     totals_o
);
  import emacc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W:0] CNT_CAP = (CNT_W + 1)'(MAX_ITEMS);

  logic [SQS_W-1:0] sq_q, sq_d, sq_new;
  logic [ABS_W-1:0] abs_q, abs_d, abs_new;
  logic [MAG_W-1:0] worst_q, worst_d, worst_new;
  logic [CNT_W-1:0] mis_q, mis_d, mis_new;
  logic [HDS_W-1:0] hds_q, hds_d, hds_new;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_new;

  logic [SQS_W:0]   sq_sum;
  logic [ABS_W:0]   abs_sum;
  logic [HDS_W:0]   hds_sum;
  logic [CNT_W:0]   mis_sum, cnt_sum;
  logic [CNT_W+CNT_O_W-1:0] mis_ext, cnt_ext;

  always_comb begin
    sq_sum  = {1'b0, sq_q} + (SQS_W + 1)'(pair_i.sqr);
    sq_new  = (sq_sum > {1'b0, SQ_CAP}) ? SQ_CAP : sq_sum[SQS_W-1:0];
    abs_sum = {1'b0, abs_q} + (ABS_W + 1)'(pair_i.mag);
    abs_new = (abs_sum > {1'b0, ABS_CAP}) ? ABS_CAP : abs_sum[ABS_W-1:0];
    worst_new = (pair_i.mag > worst_q) ? pair_i.mag : worst_q;
    hds_sum = {1'b0, hds_q} + (HDS_W + 1)'(pair_i.hd);
    hds_new = (hds_sum > {1'b0, HD_CAP}) ? HD_CAP : hds_sum[HDS_W-1:0];
    mis_sum = {1'b0, mis_q} + (CNT_W + 1)'(pair_i.mismatch);
    mis_new = (mis_sum > CNT_CAP) ? CNT_CAP[CNT_W-1:0] : mis_sum[CNT_W-1:0];
    cnt_sum = {1'b0, cnt_q} + (CNT_W + 1)'(1);
    cnt_new = (cnt_sum > CNT_CAP) ? CNT_CAP[CNT_W-1:0] : cnt_sum[CNT_W-1:0];
  end

  always_comb begin
    sq_d    = sq_q;
    abs_d   = abs_q;
    worst_d = worst_q;
    mis_d   = mis_q;
    hds_d   = hds_q;
    cnt_d   = cnt_q;
    if (upd_i) begin
      if (pair_i.last) begin
        sq_d    = '0;
        abs_d   = '0;
        worst_d = '0;
        mis_d   = '0;
        hds_d   = '0;
        cnt_d   = '0;
      end else begin
        sq_d    = sq_new;
        abs_d   = abs_new;
        worst_d = worst_new;
        mis_d   = mis_new;
        hds_d   = hds_new;
        cnt_d   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q    <= '0;
      abs_q   <= '0;
      worst_q <= '0;
      mis_q   <= '0;
      hds_q   <= '0;
      cnt_q   <= '0;
    end else begin
      sq_q    <= sq_d;
      abs_q   <= abs_d;
      worst_q <= worst_d;
      mis_q   <= mis_d;
      hds_q   <= hds_d;
      cnt_q   <= cnt_d;
    end
  end

  // counters may be narrower or wider than their fields
  assign mis_ext = {{CNT_O_W{1'b0}}, mis_new};
  assign cnt_ext = {{CNT_O_W{1'b0}}, cnt_new};

  always_comb begin
    totals_o.squared_sum      = sq_new;
    totals_o.absolute_sum     = abs_new;
    totals_o.worst_difference = worst_new;
    totals_o.mismatch_total   = mis_ext[CNT_O_W-1:0];
    totals_o.bit_distance_sum = hds_new;
    totals_o.items_seen       = cnt_ext[CNT_O_W-1:0];
  end

endmodule

`default_nettype wire

/* src/emacc_checker.sv */
// emacc_checker: port-level assertions for error_metrics_accumulator, bound
// to the top level. Depends on emacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emacc_checker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_o,
  input  wire emacc_pkg::in_t  in_data_i,
  input  wire logic            out_valid_o,
  input  wire logic            out_stall_i,
  input  wire emacc_pkg::out_t out_data_o
);
  import emacc_pkg::*;

  logic [DIFF_W-1:0] out_mag;

  assign out_mag = out_data_o.difference[DIFF_W-1] ? DIFF_W'(-out_data_o.difference)
                                                   : DIFF_W'(out_data_o.difference);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed under stall");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed under stall");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_worst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_data_o.worst_difference} >= out_mag)
    else $error("worst difference below current difference");

  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.mismatch_total <= out_data_o.items_seen
                    && out_data_o.items_seen != '0)
    else $error("mismatch or item count inconsistent");

endmodule

bind error_metrics_accumulator emacc_checker u_emacc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
